@@ hw/rtl/bgld_pkg.sv @@
// Shared types, constants and helpers for the burst and gap loss density block.
`timescale 1ns / 1ps

package bgld_pkg;

  // Width of every packet and loss counter
  localparam int COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  // Wide enough for a count plus a received run plus one
  localparam int SUM_BITS = COUNT_BITS + 9;

  // Received run stops here
  localparam logic [7:0] RUN_MAX = 8'd255;
  localparam logic [7:0] THR_RESET = 8'd16;

  // Register map (word index)
  localparam logic REG_GAP_THRESHOLD = 1'b0;

  // Density format: unsigned Q1.16, one is 65536
  localparam int FRAC_BITS = 16;
  localparam int DENS_BITS = FRAC_BITS + 1;
  localparam logic [DENS_BITS-1:0] ONE_Q16 = {1'b1, {FRAC_BITS{1'b0}}};
  localparam int STEP_BITS = $clog2(FRAC_BITS);

  // Result word layout
  localparam int OUT_CNT_BITS = 16;
  localparam int OUT_BITS = 104;

  // Queue between the accumulator and the divider
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [SUM_BITS-1:0] sum_t;

  // Window totals handed from the accumulator to the divider
  typedef struct packed {
    logic overflow;
    cnt_t gap_packets;
    cnt_t gap_losses;
    cnt_t burst_packets;
    cnt_t burst_losses;
  } bgld_totals_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BURST,
    ST_GAP,
    ST_DONE
  } bgld_state_t;

  // Saturate a widened sum to a count; top bit flags saturation
  function automatic logic [COUNT_BITS:0] sat_cnt(input sum_t s);
    logic [COUNT_BITS:0] r;
    if (s > sum_t'(COUNT_MAX)) begin
      r = {1'b1, COUNT_MAX};
    end else begin
      r = {1'b0, s[COUNT_BITS-1:0]};
    end
    return r;
  endfunction

  // Fit a count into a 16-bit result field
  function automatic logic [OUT_CNT_BITS-1:0] to_out(input cnt_t c);
    logic [31:0] w;
    w = 32'(c);
    return w[OUT_CNT_BITS-1:0];
  endfunction

endpackage

@@ hw/rtl/bgld_front.sv @@
// Per-packet accumulator: cluster tracking, burst and window totals.
`timescale 1ns / 1ps

module bgld_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            gap_threshold,
  input  logic                  accept,
  input  logic                  lost,
  input  logic                  last,
  output logic                  push,
  output bgld_pkg::bgld_totals_t totals
);
  import bgld_pkg::*;

  cnt_t       cl_losses;
  cnt_t       cl_span;
  logic [7:0] run;
  cnt_t       burst_loss;
  cnt_t       burst_len;
  cnt_t       win_losses;
  cnt_t       win_len;
  logic       saturated;

  cnt_t       cl_losses_next;
  cnt_t       cl_span_next;
  logic [7:0] run_next;
  cnt_t       burst_loss_next;
  cnt_t       burst_len_next;
  cnt_t       win_losses_next;
  cnt_t       win_len_next;
  logic       saturated_next;

  logic [7:0]          thr;
  logic                extend;
  logic                start_new;
  logic                add_en;
  cnt_t                add_losses;
  cnt_t                add_span;
  logic [COUNT_BITS:0] s_len, s_los, s_cl, s_span, s_bl, s_bt;

  // Work out the state after this packet
  always_comb begin
    thr       = (gap_threshold == 8'd0) ? 8'd1 : gap_threshold;
    extend    = lost && (cl_losses != '0) && (run < thr);
    start_new = lost && !extend;

    s_len  = sat_cnt(sum_t'(win_len) + sum_t'(1));
    s_los  = sat_cnt(sum_t'(win_losses) + sum_t'(1));
    s_cl   = sat_cnt(sum_t'(cl_losses) + sum_t'(1));
    s_span = sat_cnt(sum_t'(cl_span) + sum_t'(run) + sum_t'(1));

    win_len_next    = s_len[COUNT_BITS-1:0];
    win_losses_next = lost ? s_los[COUNT_BITS-1:0] : win_losses;

    if (extend) begin
      cl_losses_next = s_cl[COUNT_BITS-1:0];
      cl_span_next   = s_span[COUNT_BITS-1:0];
    end else if (start_new) begin
      cl_losses_next = cnt_t'(1);
      cl_span_next   = cnt_t'(1);
    end else begin
      cl_losses_next = cl_losses;
      cl_span_next   = cl_span;
    end

    // At most one cluster closes into the burst totals per packet
    add_en = (start_new && (cl_losses >= cnt_t'(2))) ||
             (last && !start_new && (cl_losses_next >= cnt_t'(2)));
    add_losses = start_new ? cl_losses : cl_losses_next;
    add_span   = start_new ? cl_span   : cl_span_next;

    s_bl = sat_cnt(sum_t'(burst_loss) + sum_t'(add_losses));
    s_bt = sat_cnt(sum_t'(burst_len) + sum_t'(add_span));
    burst_loss_next = add_en ? s_bl[COUNT_BITS-1:0] : burst_loss;
    burst_len_next  = add_en ? s_bt[COUNT_BITS-1:0] : burst_len;

    saturated_next = saturated || s_len[COUNT_BITS] ||
                     (lost && s_los[COUNT_BITS]) ||
                     (extend && (s_cl[COUNT_BITS] || s_span[COUNT_BITS])) ||
                     (add_en && (s_bl[COUNT_BITS] || s_bt[COUNT_BITS]));

    if (lost) begin
      run_next = 8'd0;
    end else if (run < RUN_MAX) begin
      run_next = run + 8'd1;
    end else begin
      run_next = run;
    end
  end

  // Form the window totals on the last packet
  always_comb begin
    push                 = accept && last;
    totals.overflow      = saturated_next;
    totals.burst_losses  = burst_loss_next;
    totals.burst_packets = burst_len_next;
    totals.gap_losses    = (win_losses_next >= burst_loss_next) ?
                           (win_losses_next - burst_loss_next) : '0;
    totals.gap_packets   = (win_len_next >= burst_len_next) ?
                           (win_len_next - burst_len_next) : '0;
  end

  // Advance on each accepted item, clear at the end of a window
  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      cl_losses  <= '0;
      cl_span    <= '0;
      run        <= 8'd0;
      burst_loss <= '0;
      burst_len  <= '0;
      win_losses <= '0;
      win_len    <= '0;
      saturated  <= 1'b0;
    end else if (accept) begin
      cl_losses  <= cl_losses_next;
      cl_span    <= cl_span_next;
      run        <= run_next;
      burst_loss <= burst_loss_next;
      burst_len  <= burst_len_next;
      win_losses <= win_losses_next;
      win_len    <= win_len_next;
      saturated  <= saturated_next;
    end
  end

endmodule

@@ hw/rtl/bgld_queue.sv @@
// Short queue of window totals between the accumulator and the divider.
`timescale 1ns / 1ps

module bgld_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  bgld_pkg::bgld_totals_t push_data,
  input  logic                   pop,
  output bgld_pkg::bgld_totals_t pop_data,
  output logic                   full,
  output logic                   empty
);
  import bgld_pkg::*;

  bgld_totals_t           mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QPTR_BITS:0]     count;

  localparam logic [QPTR_BITS-1:0] PTR_LAST = QPTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [QPTR_BITS:0]   COUNT_FULL = (QPTR_BITS + 1)'(QUEUE_DEPTH);

  assign full     = (count == COUNT_FULL);
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  // Store an entry on push
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/bgld_back.sv @@
// Density divider and result register: one quotient bit per cycle, two divisions.
`timescale 1ns / 1ps

module bgld_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  input  bgld_pkg::bgld_totals_t q_data,
  output logic                   pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [bgld_pkg::OUT_BITS-1:0] m_tdata
);
  import bgld_pkg::*;

  bgld_state_t state, state_next;

  bgld_totals_t            ent;
  cnt_t                    den;
  cnt_t                    rem;
  logic [FRAC_BITS-1:0]    quo;
  logic [STEP_BITS-1:0]    step;
  logic [DENS_BITS-1:0]    burst_q;
  logic [DENS_BITS-1:0]    gap_q;

  localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(FRAC_BITS - 1);

  logic                 dividing;
  logic                 step_last;
  logic                 load_out;
  logic [COUNT_BITS:0]  trial;
  logic                 ge;
  cnt_t                 rem_step;
  logic [FRAC_BITS-1:0] quo_step;
  cnt_t                 losses;
  logic [DENS_BITS-1:0] dens;
  cnt_t                 gap_den;
  cnt_t                 burst_den;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (!q_empty) state_next = ST_BURST;
      ST_BURST: if (step == STEP_LAST) state_next = ST_GAP;
      ST_GAP:   if (step == STEP_LAST) state_next = ST_DONE;
      ST_DONE:  if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop       = 1'b0;
    dividing  = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      ST_IDLE:  pop = !q_empty;
      ST_BURST: dividing = 1'b1;
      ST_GAP:   dividing = 1'b1;
      ST_DONE:  load_out = !m_tvalid || m_tready;
      default:  pop = 1'b0;
    endcase
    step_last = dividing && (step == STEP_LAST);
  end

  // One restoring division step and the density it yields
  always_comb begin
    trial    = {rem, 1'b0};
    ge       = (trial >= {1'b0, den});
    rem_step = ge ? COUNT_BITS'(trial - {1'b0, den}) : trial[COUNT_BITS-1:0];
    quo_step = {quo[FRAC_BITS-2:0], ge};
    losses   = (state == ST_GAP) ? ent.gap_losses : ent.burst_losses;
    // Losses at or above length give one, or zero when there are none
    if (losses >= den) begin
      dens = (losses != '0) ? ONE_Q16 : '0;
    end else begin
      dens = {1'b0, quo_step};
    end
    burst_den = (q_data.burst_packets == '0) ? cnt_t'(1) : q_data.burst_packets;
    gap_den   = (ent.gap_packets == '0) ? cnt_t'(1) : ent.gap_packets;
  end

  // Divider datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      ent  <= q_data;
      den  <= burst_den;
      rem  <= (q_data.burst_losses >= burst_den) ? '0 : q_data.burst_losses;
      quo  <= '0;
    end else if (step_last && (state == ST_BURST)) begin
      burst_q <= dens;
      den     <= gap_den;
      rem     <= (ent.gap_losses >= gap_den) ? '0 : ent.gap_losses;
      quo     <= '0;
    end else if (step_last) begin
      gap_q <= dens;
      rem   <= rem_step;
      quo   <= quo_step;
    end else if (dividing) begin
      rem <= rem_step;
      quo <= quo_step;
    end
  end

  // State and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= dividing ? ((step == STEP_LAST) ? '0 : step + 1'b1) : '0;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {5'b0, ent.overflow,
                  to_out(ent.gap_packets), to_out(ent.gap_losses),
                  to_out(ent.burst_packets), to_out(ent.burst_losses),
                  gap_q, burst_q};
    end
  end

  // The partial remainder stays below the divisor while dividing
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    dividing |-> (rem < den))
    else $error("division remainder reached divisor");

  // A loaded result shows as valid next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load_out |=> m_tvalid)
    else $error("result loaded but not presented");

  // Densities never exceed one
  a_dens_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[16:0] <= ONE_Q16) && (m_tdata[33:17] <= ONE_Q16)))
    else $error("density above one");

endmodule

@@ hw/rtl/burst_gap_loss_density.sv @@
// Top level: configuration register, accumulator, totals queue and density divider.
//
//  Channel   Direction  Payload
//  s_*       in         tdata[0] lost, tlast last
//  m_*       out        tdata: burst/gap density, burst/gap losses and packets, overflow
//  APB       in/out     word 0: gap_threshold [7:0]
//
// Packets are taken one per cycle; only a window's last packet pushes its totals
// into a two-entry queue, and the input stalls while that queue is full.
// For each window the divider loads the totals, runs a bit-serial restoring divide
// for burst then gap density, and then places the result in the output register.
// Reset (rst, synchronous) clears counts, queue and result valid; gap_threshold
// returns to 16. No clearing pass is needed.
`timescale 1ns / 1ps

module burst_gap_loss_density (
  input  logic         clk,
  input  logic         rst,
  // Input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [0] lost, [7:1] zero
  input  logic         s_tlast,
  // Result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // [16:0] burst loss density, [33:17] gap loss density, [49:34] burst_losses,
  // [65:50] burst_packets, [81:66] gap_losses, [97:82] gap_packets,
  // [98] overflow, [103:99] zero
  output logic [bgld_pkg::OUT_BITS-1:0] m_tdata,
  // Configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import bgld_pkg::*;

  logic [7:0]   gap_threshold;
  logic         accept;
  logic         push;
  logic         pop;
  logic         q_full;
  logic         q_empty;
  bgld_totals_t push_data;
  bgld_totals_t pop_data;

  assign pready   = 1'b1;
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // Register write on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_threshold <= THR_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_GAP_THRESHOLD)) begin
      gap_threshold <= pwdata[7:0];
    end
  end

  // Register read back
  always_comb begin
    prdata = (paddr[2] == REG_GAP_THRESHOLD) ? {24'b0, gap_threshold} : 32'b0;
  end

  bgld_front u_front (
    .clk           (clk),
    .rst           (rst),
    .gap_threshold (gap_threshold),
    .accept        (accept),
    .lost          (s_tdata[0]),
    .last          (s_tlast),
    .push          (push),
    .totals        (push_data)
  );

  bgld_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  bgld_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (pop_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
